// ===== rtl/core/owm_pkg.sv =====
// Shared types and constants for the one-wire master with search.
package owm_pkg;

    localparam logic [2:0] OP_RESET     = 3'd0;
    localparam logic [2:0] OP_WRITE     = 3'd1;
    localparam logic [2:0] OP_READ      = 3'd2;
    localparam logic [2:0] OP_SBEGIN    = 3'd3;
    localparam logic [2:0] OP_SNEXT     = 3'd4;
    localparam logic [2:0] OP_READ_ROM  = 3'd5;
    localparam logic [2:0] OP_MATCH_ROM = 3'd6;
    localparam logic [2:0] OP_SKIP_ROM  = 3'd7;

    localparam logic [7:0] CMD_READ_ROM  = 8'h33;
    localparam logic [7:0] CMD_MATCH_ROM = 8'h55;
    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;

    localparam logic [2:0] CFG_RESET_LOW  = 3'd0;
    localparam logic [2:0] CFG_PRES_SMP   = 3'd1;
    localparam logic [2:0] CFG_RESET_TAIL = 3'd2;
    localparam logic [2:0] CFG_SLOT_LEN   = 3'd3;
    localparam logic [2:0] CFG_W0_LOW     = 3'd4;
    localparam logic [2:0] CFG_SHORT_LOW  = 3'd5;
    localparam logic [2:0] CFG_READ_SMP   = 3'd6;

    localparam logic [6:0] NONE7 = 7'h7F;

    typedef struct packed {
        logic        command_valid;
        logic [2:0]  operation;
        logic [6:0]  bit_count;
        logic [63:0] write_value;
        logic [7:0]  search_command;
        logic        bus_sample;
    } t_in_word;

    typedef struct packed {
        logic        bus_drive_low;
        logic        busy_res;
        logic        done_res;
        logic        presence;
        logic [63:0] read_value;
        logic        no_device;
    } t_out_word;

    typedef struct packed {
        logic [9:0] reset_low;
        logic [9:0] pres_smp;
        logic [9:0] reset_tail;
        logic [9:0] slot_len;
        logic [9:0] w0_low;
        logic [9:0] short_low;
        logic [9:0] read_smp;
    } t_cfg;

endpackage

// ===== rtl/core/one_wire_master_with_search_unit.sv =====
// Top level of the one-wire bus master with ROM search.
// Each input word is one microsecond bus tick and yields exactly one output word with the
// drive level and status; one word is taken per clock cycle while the output is not stalled,
// passing through the input queue and then the registered engine output. The combinational
// engine state update for one tick sets this rate.
module one_wire_master_with_search_unit #(
    parameter int ADDRESS_BITS = 64,
    parameter int TIMER_WIDTH  = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  owm_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_stall,
    output owm_pkg::t_out_word o_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_data
);
    owm_pkg::t_cfg r_cfg;
    owm_pkg::t_in_word q_word;
    logic q_valid, q_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{10'd480, 10'd70, 10'd410, 10'd70, 10'd60, 10'd6, 10'd15};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                owm_pkg::CFG_RESET_LOW:  r_cfg.reset_low  <= i_cfg_data;
                owm_pkg::CFG_PRES_SMP:   r_cfg.pres_smp   <= i_cfg_data;
                owm_pkg::CFG_RESET_TAIL: r_cfg.reset_tail <= i_cfg_data;
                owm_pkg::CFG_SLOT_LEN:   r_cfg.slot_len   <= i_cfg_data;
                owm_pkg::CFG_W0_LOW:     r_cfg.w0_low     <= i_cfg_data;
                owm_pkg::CFG_SHORT_LOW:  r_cfg.short_low  <= i_cfg_data;
                owm_pkg::CFG_READ_SMP:   r_cfg.read_smp   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    owm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_word(i_word), .o_valid(q_valid), .i_take(q_take), .o_word(q_word)
    );

    owm_engine #(.ADDRESS_BITS(ADDRESS_BITS), .TIMER_WIDTH(TIMER_WIDTH)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_valid(q_valid),
        .o_take(q_take), .i_word(q_word), .o_valid(o_valid), .i_stall(i_stall),
        .o_word(o_word)
    );

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.no_device |-> o_word.done_res)
        else $error("no_device without done");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word))
        else $error("stalled output changed");
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.bus_drive_low |-> o_word.busy_res)
        else $error("drive while idle");
endmodule

// ===== rtl/core/owm_front.sv =====
// Input skid stage: accepts tick words and queues them for the engine.
module owm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  owm_pkg::t_in_word i_word,
    output logic              o_valid,
    input  logic              i_take,
    output owm_pkg::t_in_word o_word
);
    // two-entry queue
    owm_pkg::t_in_word r_q0, r_q1;
    logic [1:0] r_cnt;
    logic acc, take;

    assign o_stall = (r_cnt == 2'd2);
    assign acc = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign take = o_valid && i_take;
    assign o_word = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, acc} - {1'b0, take};
        end
        if (take) begin
            if (r_cnt == 2'd2) r_q0 <= r_q1;
            else if (acc) r_q0 <= i_word;
            if (acc) r_q1 <= i_word;
        end else if (acc) begin
            if (r_cnt == 2'd0) r_q0 <= i_word;
            else r_q1 <= i_word;
        end
    end
endmodule

// ===== rtl/core/owm_engine.sv =====
// Bus engine: executes one tick of the reset, slot and search sequencing per word.
module owm_engine #(
    parameter int ADDRESS_BITS = 64,
    parameter int TIMER_WIDTH  = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  owm_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    output logic               o_take,
    input  owm_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_stall,
    output owm_pkg::t_out_word o_word
);
    localparam logic [2:0] PH_IDLE = 3'd0, PH_RLOW = 3'd1, PH_RWAIT = 3'd2,
                           PH_RTAIL = 3'd3, PH_SLOT = 3'd4;
    localparam logic [1:0] ST_CMD = 2'd0, ST_DATA = 2'd1, ST_SEARCH = 2'd2;
    localparam logic [6:0] ABITS = 7'(ADDRESS_BITS);
    localparam logic [63:0] AMASK = {64{1'b1}} >> (64 - ADDRESS_BITS);

    logic [2:0] r_phase, n_phase;
    logic [TIMER_WIDTH-1:0] r_tmr, n_tmr;
    logic [6:0] r_bi, n_bi, r_ld, n_ld, r_lz, n_lz, r_len, n_len;
    logic [63:0] r_sh, n_sh, r_la, n_la;
    logic [2:0] r_op, n_op;
    logic [7:0] r_ssc, n_ssc, r_cb, n_cb;
    logic r_fsb, n_fsb, r_pres, n_pres, r_smpd, n_smpd, r_fin, n_fin;
    logic [1:0] r_stage, n_stage, r_sub, n_sub;
    owm_pkg::t_out_word r_out, n_out;
    logic r_ov;

    logic go;
    assign o_take = i_valid && !(r_ov && i_stall);
    assign go = o_take;
    assign o_valid = r_ov;
    assign o_word = r_out;

    function automatic logic [9:0] ao(input logic [9:0] v);
        return (v == 10'd0) ? 10'd1 : v;
    endfunction

    always_comb begin
        logic done, nd, drive, busy, is_read, wbit, path;
        logic [63:0] val;
        logic [9:0] len, low, smp;
        logic [TIMER_WIDTH:0] t1;
        logic [5:0] bx;
        n_phase = r_phase; n_tmr = r_tmr; n_bi = r_bi; n_ld = r_ld; n_lz = r_lz;
        n_len = r_len; n_sh = r_sh; n_la = r_la; n_op = r_op; n_ssc = r_ssc;
        n_cb = r_cb; n_fsb = r_fsb; n_pres = r_pres; n_smpd = r_smpd; n_fin = r_fin;
        n_stage = r_stage; n_sub = r_sub;
        done = 1'b0; nd = 1'b0; val = 64'd0; drive = 1'b0; busy = 1'b0;
        is_read = 1'b0; wbit = 1'b0; path = 1'b0;
        len = ao(i_cfg.slot_len); low = 10'd0; smp = 10'd0; bx = 6'd0;
        // accept command
        if (r_phase == PH_IDLE && i_word.command_valid) begin
            n_op = i_word.operation; n_bi = 7'd0; n_tmr = '0;
            unique case (i_word.operation)
                owm_pkg::OP_SBEGIN: begin
                    n_ssc = i_word.search_command; n_la = 64'd0; n_ld = owm_pkg::NONE7;
                    n_fin = 1'b0; done = 1'b1;
                end
                owm_pkg::OP_WRITE, owm_pkg::OP_READ: begin
                    if (i_word.bit_count == 7'd0) done = 1'b1;
                    else begin
                        n_len = (i_word.bit_count > 7'd64) ? 7'd64 : i_word.bit_count;
                        n_stage = ST_DATA;
                        n_sh = (i_word.operation == owm_pkg::OP_WRITE) ?
                               i_word.write_value : 64'd0;
                        n_phase = PH_SLOT;
                    end
                end
                owm_pkg::OP_SNEXT: begin
                    if (r_fin) begin done = 1'b1; nd = 1'b1; end
                    else begin n_cb = r_ssc; n_phase = PH_RLOW; end
                end
                owm_pkg::OP_READ_ROM: begin n_cb = owm_pkg::CMD_READ_ROM; n_phase = PH_RLOW; end
                owm_pkg::OP_MATCH_ROM: begin
                    n_cb = owm_pkg::CMD_MATCH_ROM; n_sh = i_word.write_value & AMASK;
                    n_phase = PH_RLOW;
                end
                owm_pkg::OP_SKIP_ROM: begin n_cb = owm_pkg::CMD_SKIP_ROM; n_phase = PH_RLOW; end
                owm_pkg::OP_RESET: n_phase = PH_RLOW;
            endcase
        end
        t1 = {1'b0, n_tmr} + 1'b1;
        if (n_phase != PH_IDLE) begin
            busy = 1'b1;
            unique case (n_phase)
                PH_RLOW: begin
                    drive = 1'b1;
                    if (t1 >= (TIMER_WIDTH+1)'(ao(i_cfg.reset_low))) begin
                        n_phase = PH_RWAIT; n_tmr = '0;
                    end else n_tmr = t1[TIMER_WIDTH-1:0];
                end
                PH_RWAIT: begin
                    if (t1 >= (TIMER_WIDTH+1)'(ao(i_cfg.pres_smp))) begin
                        n_pres = !i_word.bus_sample; n_phase = PH_RTAIL; n_tmr = '0;
                    end else n_tmr = t1[TIMER_WIDTH-1:0];
                end
                PH_RTAIL: begin
                    if (t1 >= (TIMER_WIDTH+1)'(ao(i_cfg.reset_tail))) begin
                        n_tmr = '0;
                        if (n_op == owm_pkg::OP_RESET) begin done = 1'b1; n_phase = PH_IDLE; end
                        else if (!n_pres) begin
                            done = 1'b1; nd = 1'b1; n_phase = PH_IDLE;
                        end else begin
                            n_stage = ST_CMD; n_bi = 7'd0; n_phase = PH_SLOT;
                        end
                    end else n_tmr = t1[TIMER_WIDTH-1:0];
                end
                default: begin
                    bx = n_bi[5:0];
                    if (n_stage == ST_CMD) wbit = n_cb[n_bi[2:0]];
                    else begin
                        wbit = n_sh[bx];
                        is_read = (n_stage == ST_DATA) ?
                            (n_op == owm_pkg::OP_READ || n_op == owm_pkg::OP_READ_ROM) :
                            (n_sub < 2'd2);
                    end
                    low = ao((is_read || wbit) ? i_cfg.short_low : i_cfg.w0_low);
                    drive = (10'(n_tmr) < low);
                    smp = (i_cfg.read_smp < len) ? i_cfg.read_smp : len - 10'd1;
                    if (is_read && 10'(n_tmr) == smp) n_smpd = i_word.bus_sample;
                    if (t1 >= (TIMER_WIDTH+1)'(len)) begin
                        n_tmr = '0;
                        if (n_stage == ST_CMD) begin
                            n_bi = n_bi + 7'd1;
                            if (n_bi == 7'd8) begin
                                n_bi = 7'd0;
                                if (n_op == owm_pkg::OP_SNEXT) begin
                                    n_stage = ST_SEARCH; n_sub = 2'd0;
                                    n_lz = owm_pkg::NONE7; n_sh = 64'd0;
                                end else if (n_op == owm_pkg::OP_READ_ROM) begin
                                    n_stage = ST_DATA; n_len = ABITS; n_sh = 64'd0;
                                end else if (n_op == owm_pkg::OP_MATCH_ROM) begin
                                    n_stage = ST_DATA; n_len = ABITS;
                                end else begin
                                    done = 1'b1; n_phase = PH_IDLE;
                                end
                            end
                        end else if (n_stage == ST_DATA) begin
                            if (is_read && n_smpd) n_sh[bx] = 1'b1;
                            n_bi = n_bi + 7'd1;
                            if (n_bi >= n_len) begin
                                done = 1'b1; n_phase = PH_IDLE;
                                val = is_read ? n_sh : 64'd0;
                            end
                        end else begin
                            if (n_sub == 2'd0) begin
                                n_fsb = n_smpd; n_sub = 2'd1;
                            end else if (n_sub == 2'd1) begin
                                if (n_fsb != n_smpd) path = n_fsb;
                                else if (n_fsb) begin
                                    done = 1'b1; nd = 1'b1; n_phase = PH_IDLE;
                                end else begin
                                    if (r_ld != owm_pkg::NONE7 && n_bi < r_ld) path = r_la[bx];
                                    else path = (r_ld != owm_pkg::NONE7 && n_bi == r_ld);
                                    if (!path) n_lz = n_bi;
                                end
                                if (path) n_sh[bx] = 1'b1;
                                n_sub = 2'd2;
                            end else begin
                                n_sub = 2'd0;
                                n_bi = n_bi + 7'd1;
                                if (n_bi >= ABITS) begin
                                    n_la = n_sh; n_ld = n_lz;
                                    n_fin = (n_lz == owm_pkg::NONE7);
                                    done = 1'b1; n_phase = PH_IDLE; val = n_sh;
                                end
                            end
                        end
                    end else n_tmr = t1[TIMER_WIDTH-1:0];
                end
            endcase
        end
        n_out.bus_drive_low = drive;
        n_out.busy_res = busy;
        n_out.done_res = done;
        n_out.presence = n_pres;
        n_out.read_value = val;
        n_out.no_device = nd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_tmr <= '0; r_bi <= '0; r_ld <= owm_pkg::NONE7;
            r_lz <= owm_pkg::NONE7; r_len <= '0; r_sh <= '0; r_la <= '0; r_op <= '0;
            r_ssc <= '0; r_cb <= '0; r_fsb <= 1'b0; r_pres <= 1'b0; r_smpd <= 1'b0;
            r_fin <= 1'b0; r_stage <= ST_CMD; r_sub <= '0; r_ov <= 1'b0;
        end else begin
            if (go) begin
                r_phase <= n_phase; r_tmr <= n_tmr; r_bi <= n_bi; r_ld <= n_ld;
                r_lz <= n_lz; r_len <= n_len; r_sh <= n_sh; r_la <= n_la; r_op <= n_op;
                r_ssc <= n_ssc; r_cb <= n_cb; r_fsb <= n_fsb; r_pres <= n_pres;
                r_smpd <= n_smpd; r_fin <= n_fin; r_stage <= n_stage; r_sub <= n_sub;
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
        if (go) r_out <= n_out;
    end
endmodule

// ===== tb/tb_one_wire_master_with_search_unit.sv =====
// Self-checking testbench for the one-wire bus master with ROM search.
`timescale 1ns / 1ps

module tb_one_wire_master_with_search_unit;

    localparam int CYCLE_LIMIT = 40000;
    localparam int NO_BIT      = 127;
    localparam int PHASE_ITEMS = 15;

    typedef enum int { P_IDLE, P_RLOW, P_RWAIT, P_RTAIL, P_SLOT } t_bus_phase;
    typedef enum int { S_CMD, S_DATA, S_SEARCH } t_stage;
    // bus population: 0..2 devices, 3 presence only, 4 random noise
    typedef enum int { BUS_NONE, BUS_ONE, BUS_TWO, BUS_PRES_ONLY, BUS_NOISE } t_bus_mode;

    typedef struct {
        owm_pkg::t_in_word  w;
        t_bus_mode          mode;
        bit                 drain;
        bit                 typed;
        owm_pkg::t_out_word want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    owm_pkg::t_in_word  i_word = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    owm_pkg::t_out_word o_word;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = owm_pkg::CFG_RESET_LOW;
    logic [9:0]         i_cfg_data = '0;

    one_wire_master_with_search_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_word      (i_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word      (o_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predicted engine state
    int          m_cfg [7];
    t_bus_phase  m_ph;
    t_stage      m_stage;
    int          m_tmr, m_bidx, m_ldisc, m_lzero, m_sub, m_dlen;
    logic [2:0]  m_op;
    logic [63:0] m_sdata, m_laddr;
    logic [7:0]  m_scmd, m_cmdb;
    bit          m_fsb, m_pres, m_smp, m_sfin;
    bit          m_done, m_nd;
    logic [63:0] m_val;

    owm_pkg::t_out_word pending_bus_words [$];
    t_bus_mode   bus_mode;
    logic [63:0] rom_a, rom_b;
    int          errors = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_cnt = 0;
    t_row        rows [$];

    function automatic int al1(int v);
        return (v == 0) ? 1 : v;
    endfunction

    function void finish_cmd(logic [63:0] v, bit nd);
        m_ph   = P_IDLE;
        m_tmr  = 0;
        m_done = 1'b1;
        m_val  = v;
        m_nd   = nd;
    endfunction

    function void open_slot();
        m_ph  = P_SLOT;
        m_tmr = 0;
    endfunction

    function bit op_reads();
        return m_op == owm_pkg::OP_READ || m_op == owm_pkg::OP_READ_ROM;
    endfunction

    function void after_bus_reset();
        if (m_op == owm_pkg::OP_RESET) begin
            finish_cmd('0, 1'b0);
        end else if (!m_pres) begin
            finish_cmd('0, 1'b1);
        end else begin
            m_stage = S_CMD;
            m_bidx  = 0;
            open_slot();
        end
    endfunction

    function void after_slot();
        bit a, c, path;
        if (m_stage == S_CMD) begin
            m_bidx++;
            if (m_bidx < 8) begin
                open_slot();
                return;
            end
            m_bidx = 0;
            if (m_op == owm_pkg::OP_SNEXT) begin
                m_stage = S_SEARCH; m_sub = 0; m_lzero = NO_BIT; m_sdata = '0;
            end else if (m_op == owm_pkg::OP_READ_ROM) begin
                m_stage = S_DATA; m_dlen = 64; m_sdata = '0;
            end else if (m_op == owm_pkg::OP_MATCH_ROM) begin
                m_stage = S_DATA; m_dlen = 64;
            end else begin
                finish_cmd('0, 1'b0);
                return;
            end
            open_slot();
            return;
        end
        if (m_stage == S_DATA) begin
            if (op_reads() && m_smp) m_sdata[m_bidx & 63] = 1'b1;
            m_bidx++;
            if (m_bidx >= m_dlen) begin
                finish_cmd(op_reads() ? m_sdata : 64'd0, 1'b0);
                return;
            end
            open_slot();
            return;
        end
        // search triple: true bit, complement, chosen direction
        if (m_sub == 0) begin
            m_fsb = m_smp;
            m_sub = 1;
        end else if (m_sub == 1) begin
            a = m_fsb;
            c = m_smp;
            if (a != c) begin
                path = a;
            end else begin
                if (a && c) begin
                    finish_cmd('0, 1'b1);
                    return;
                end
                if (m_ldisc != NO_BIT && m_bidx < m_ldisc) path = m_laddr[m_bidx & 63];
                else path = (m_ldisc != NO_BIT && m_bidx == m_ldisc);
                if (!path) m_lzero = m_bidx;
            end
            if (path) m_sdata[m_bidx & 63] = 1'b1;
            m_sub = 2;
        end else begin
            m_sub = 0;
            m_bidx++;
            if (m_bidx >= 64) begin
                m_laddr = m_sdata;
                m_ldisc = m_lzero;
                m_sfin  = (m_lzero == NO_BIT);
                finish_cmd(m_sdata, 1'b0);
                return;
            end
        end
        open_slot();
    endfunction

    function void take_command(owm_pkg::t_in_word w);
        m_op   = w.operation;
        m_bidx = 0;
        m_tmr  = 0;
        if (w.operation == owm_pkg::OP_SBEGIN) begin
            m_scmd  = w.search_command;
            m_laddr = '0;
            m_ldisc = NO_BIT;
            m_sfin  = 1'b0;
            finish_cmd('0, 1'b0);
            return;
        end
        if (w.operation == owm_pkg::OP_WRITE || w.operation == owm_pkg::OP_READ) begin
            if (w.bit_count == 0) begin
                finish_cmd('0, 1'b0);
                return;
            end
            m_dlen  = (w.bit_count > 64) ? 64 : int'(w.bit_count);
            m_stage = S_DATA;
            m_sdata = (w.operation == owm_pkg::OP_WRITE) ? w.write_value : 64'd0;
            open_slot();
            return;
        end
        if (w.operation == owm_pkg::OP_SNEXT && m_sfin) begin
            finish_cmd('0, 1'b1);
            return;
        end
        case (w.operation)
            owm_pkg::OP_SNEXT:     m_cmdb = m_scmd;
            owm_pkg::OP_READ_ROM:  m_cmdb = owm_pkg::CMD_READ_ROM;
            owm_pkg::OP_MATCH_ROM: begin
                m_cmdb  = owm_pkg::CMD_MATCH_ROM;
                m_sdata = w.write_value;
            end
            default:               m_cmdb = owm_pkg::CMD_SKIP_ROM;
        endcase
        m_ph = P_RLOW;
    endfunction

    function owm_pkg::t_out_word bus_tick_predict(owm_pkg::t_in_word w);
        owm_pkg::t_out_word r;
        bit        rd, wbit;
        int        len, low, spt;
        r      = '0;
        m_done = 1'b0;
        m_val  = '0;
        m_nd   = 1'b0;
        if (m_ph == P_IDLE && w.command_valid) take_command(w);
        if (m_ph != P_IDLE) begin
            r.busy_res = 1'b1;
            case (m_ph)
                P_RLOW: begin
                    r.bus_drive_low = 1'b1;
                    if (m_tmr + 1 >= al1(m_cfg[owm_pkg::CFG_RESET_LOW])) begin
                        m_ph = P_RWAIT; m_tmr = 0;
                    end else m_tmr = (m_tmr + 1) & 1023;
                end
                P_RWAIT: begin
                    if (m_tmr + 1 >= al1(m_cfg[owm_pkg::CFG_PRES_SMP])) begin
                        m_pres = !w.bus_sample;
                        m_ph = P_RTAIL; m_tmr = 0;
                    end else m_tmr = (m_tmr + 1) & 1023;
                end
                P_RTAIL: begin
                    if (m_tmr + 1 >= al1(m_cfg[owm_pkg::CFG_RESET_TAIL])) after_bus_reset();
                    else m_tmr = (m_tmr + 1) & 1023;
                end
                default: begin
                    len = al1(m_cfg[owm_pkg::CFG_SLOT_LEN]);
                    if (m_stage == S_CMD) begin
                        rd = 1'b0; wbit = m_cmdb[m_bidx & 7];
                    end else if (m_stage == S_DATA) begin
                        rd = op_reads(); wbit = m_sdata[m_bidx & 63];
                    end else begin
                        rd = (m_sub < 2); wbit = m_sdata[m_bidx & 63];
                    end
                    low = al1((rd || wbit) ? m_cfg[owm_pkg::CFG_SHORT_LOW] :
                                             m_cfg[owm_pkg::CFG_W0_LOW]);
                    r.bus_drive_low = (m_tmr < low);
                    spt = (m_cfg[owm_pkg::CFG_READ_SMP] < len) ?
                          m_cfg[owm_pkg::CFG_READ_SMP] : len - 1;
                    if (rd && m_tmr == spt) m_smp = w.bus_sample;
                    if (m_tmr + 1 >= len) after_slot();
                    else m_tmr = (m_tmr + 1) & 1023;
                end
            endcase
        end
        r.done_res   = m_done;
        r.presence   = m_pres;
        r.read_value = m_val;
        r.no_device  = m_nd;
        return r;
    endfunction

    // wired-AND of the emulated devices for the next tick
    function bit device_bus_level();
        logic [63:0] mask;
        bit          lvl, sel_a, sel_b;
        lvl = 1'b1;
        if (bus_mode == BUS_NOISE) return 1'($urandom_range(1));
        if (bus_mode == BUS_NONE) return 1'b1;
        if (m_ph == P_RWAIT) return 1'b0;
        if (bus_mode == BUS_PRES_ONLY || m_ph != P_SLOT) return 1'b1;
        if (m_stage == S_SEARCH && m_sub < 2) begin
            mask  = (64'd1 << m_bidx) - 64'd1;
            sel_a = ((rom_a ^ m_sdata) & mask) == 0;
            sel_b = bus_mode == BUS_TWO && ((rom_b ^ m_sdata) & mask) == 0;
            if (sel_a) lvl &= rom_a[m_bidx] ^ (m_sub == 1);
            if (sel_b) lvl &= rom_b[m_bidx] ^ (m_sub == 1);
            return lvl;
        end
        if (m_stage == S_DATA && m_op == owm_pkg::OP_READ_ROM) begin
            lvl = rom_a[m_bidx & 63];
            if (bus_mode == BUS_TWO) lvl &= rom_b[m_bidx & 63];
            return lvl;
        end
        if (m_stage == S_DATA && m_op == owm_pkg::OP_READ) return 1'($urandom_range(1));
        return 1'b1;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // send one word; returns 1 if it was a command the block ignores while busy
    task automatic send_tick(input owm_pkg::t_in_word w, output bit ignored);
        while (!quiet && $urandom_range(99) < 29) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (o_stall);
        ignored = w.command_valid && m_ph != P_IDLE;
        pending_bus_words.push_back(bus_tick_predict(w));
    endtask

    function owm_pkg::t_in_word idle_word();
        owm_pkg::t_in_word w;
        w.command_valid  = 1'b0;
        w.operation      = 3'($urandom_range(7));
        w.bit_count      = 7'($urandom_range(127));
        w.write_value    = {$urandom, $urandom};
        w.search_command = 8'($urandom_range(255));
        w.bus_sample     = device_bus_level();
        return w;
    endfunction

    function owm_pkg::t_in_word make_cmd(logic [2:0] op, logic [6:0] cnt, logic [63:0] wv,
                                         logic [7:0] sc);
        owm_pkg::t_in_word w;
        w.command_valid  = 1'b1;
        w.operation      = op;
        w.bit_count      = cnt;
        w.write_value    = wv;
        w.search_command = sc;
        w.bus_sample     = 1'b1;
        return w;
    endfunction

    task automatic run_to_idle();
        bit ign;
        while (m_ph != P_IDLE) send_tick(idle_word(), ign);
        i_valid <= 1'b0;
        while (pending_bus_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_timing(input int v0, v1, v2, v3, v4, v5, v6);
        logic [2:0] idx [7];
        int         vals [7];
        idx  = '{owm_pkg::CFG_RESET_LOW, owm_pkg::CFG_PRES_SMP, owm_pkg::CFG_RESET_TAIL,
                 owm_pkg::CFG_SLOT_LEN, owm_pkg::CFG_W0_LOW, owm_pkg::CFG_SHORT_LOW,
                 owm_pkg::CFG_READ_SMP};
        vals = '{v0, v1, v2, v3, v4, v5, v6};
        for (int i = 0; i < 7; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= 10'(vals[i]);
            do @(posedge i_clk); while (!o_cfg_ready);
            m_cfg[idx[i]] = vals[i] & 1023;
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase();
        int                count;
        bit                ign;
        int                r;
        owm_pkg::t_in_word w;
        count = 0;
        while (count < PHASE_ITEMS) begin
            if (m_ph == P_IDLE && $urandom_range(99) < 85) begin
                r = $urandom_range(9);
                bus_mode = (r < 4) ? BUS_TWO : (r < 7) ? BUS_ONE : (r == 7) ? BUS_NONE :
                           (r == 8) ? BUS_PRES_ONLY : BUS_NOISE;
                w = make_cmd(3'($urandom_range(7)),
                             7'(($urandom_range(9) == 0) ? $urandom_range(127) :
                                                           $urandom_range(1, 8)),
                             {$urandom, $urandom}, 8'($urandom_range(255)));
                if (w.operation == owm_pkg::OP_SBEGIN) begin
                    rom_a = {$urandom, $urandom};
                    rom_b = {$urandom, $urandom};
                end
            end else if (m_ph != P_IDLE && $urandom_range(99) < 5) begin
                w = make_cmd(3'($urandom_range(7)), 7'($urandom_range(127)),
                             {$urandom, $urandom}, 8'($urandom_range(255)));
                w.bus_sample = device_bus_level();
            end else begin
                w = idle_word();
            end
            send_tick(w, ign);
            if (!ign) count++;
        end
        run_to_idle();
    endtask

    function t_row row(owm_pkg::t_in_word w, t_bus_mode mode, bit drain, bit typed,
                       owm_pkg::t_out_word want);
        t_row x;
        x.w = w; x.mode = mode; x.drain = drain; x.typed = typed; x.want = want;
        return x;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // output side: check, stall at random, long hold-off on request
    always @(posedge i_clk) begin
        owm_pkg::t_out_word want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_bus_words.size() == 0) begin
                    report("unexpected word", o_word.read_value, 64'd0);
                end else begin
                    want = pending_bus_words.pop_front();
                    if (o_word.bus_drive_low !== want.bus_drive_low)
                        report("bus_drive_low", 64'(o_word.bus_drive_low),
                               64'(want.bus_drive_low));
                    if (o_word.busy_res !== want.busy_res)
                        report("busy_res", 64'(o_word.busy_res), 64'(want.busy_res));
                    if (o_word.done_res !== want.done_res)
                        report("done_res", 64'(o_word.done_res), 64'(want.done_res));
                    if (o_word.presence !== want.presence)
                        report("presence", 64'(o_word.presence), 64'(want.presence));
                    if (o_word.read_value !== want.read_value)
                        report("read_value", o_word.read_value, want.read_value);
                    if (o_word.no_device !== want.no_device)
                        report("no_device", 64'(o_word.no_device), 64'(want.no_device));
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen <= hold_req;
                hold_cnt  <= 400;
                i_stall   <= 1'b1;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_stall  <= 1'b1;
            end else begin
                i_stall <= !quiet && ($urandom_range(99) < 29);
            end
        end
    end

    initial begin
        owm_pkg::t_out_word z, dn;
        bit                 ign;
        owm_pkg::t_in_word  w;
        m_cfg   = '{480, 70, 410, 70, 60, 6, 15};
        m_ph    = P_IDLE; m_stage = S_CMD; m_tmr = 0; m_bidx = 0; m_op = owm_pkg::OP_RESET;
        m_sdata = '0; m_laddr = '0; m_ldisc = NO_BIT; m_lzero = NO_BIT; m_scmd = '0;
        m_fsb   = 0; m_pres = 0; m_sub = 0; m_smp = 0; m_dlen = 0; m_cmdb = '0; m_sfin = 0;
        bus_mode = BUS_TWO;
        rom_a = {$urandom, $urandom};
        rom_b = {$urandom, $urandom};
        z  = '0;
        dn = '0;
        dn.done_res = 1'b1;

        rows.push_back(row(idle_word(), BUS_TWO, 1, 1, z));
        rows.push_back(row(make_cmd(owm_pkg::OP_SBEGIN, 7'd0, '0, 8'hF0), BUS_TWO, 1, 1, dn));
        rows.push_back(row(make_cmd(owm_pkg::OP_WRITE, 7'd0, '1, 8'h00), BUS_TWO, 1, 1, dn));
        rows.push_back(row(make_cmd(owm_pkg::OP_READ, 7'd0, '0, 8'hFF), BUS_TWO, 1, 1, dn));
        rows.push_back(row(make_cmd(owm_pkg::OP_RESET, 7'd1, '0, 8'h00), BUS_TWO, 1, 0, z));
        rows.push_back(row(make_cmd(owm_pkg::OP_WRITE, 7'd64, '1, 8'h00), BUS_TWO, 1, 0, z));
        rows.push_back(row(make_cmd(owm_pkg::OP_WRITE, 7'd8, 64'd1, 8'h00), BUS_TWO, 1, 0, z));
        rows.push_back(row(make_cmd(owm_pkg::OP_READ, 7'd100, '0, 8'h00), BUS_TWO, 1, 0, z));
        rows.push_back(row(make_cmd(owm_pkg::OP_READ, 7'd1, '0, 8'h00), BUS_TWO, 1, 0, z));
        rows.push_back(row(make_cmd(owm_pkg::OP_READ_ROM, 7'd1, '0, 8'h00), BUS_ONE, 1, 0, z));
        rows.push_back(row(make_cmd(owm_pkg::OP_SKIP_ROM, 7'd1, '0, 8'h00), BUS_TWO, 1, 0, z));
        rows.push_back(row(make_cmd(owm_pkg::OP_SBEGIN, 7'd0, '0, 8'h0F), BUS_TWO, 1, 0, z));
        rows.push_back(row(make_cmd(owm_pkg::OP_SNEXT, 7'd0, '0, 8'h00), BUS_TWO, 1, 0, z));
        rows.push_back(row(make_cmd(owm_pkg::OP_SNEXT, 7'd0, '0, 8'h00), BUS_TWO, 1, 0, z));
        // past the last device: ends at once
        rows.push_back(row(make_cmd(owm_pkg::OP_SNEXT, 7'd0, '0, 8'h00), BUS_TWO, 1, 0, z));
        // second command while busy is dropped
        rows.push_back(row(make_cmd(owm_pkg::OP_RESET, 7'd0, '0, 8'h00), BUS_TWO, 0, 0, z));
        rows.push_back(row(make_cmd(owm_pkg::OP_WRITE, 7'd3, '1, 8'h00), BUS_TWO, 1, 0, z));
        rows.push_back(row(make_cmd(owm_pkg::OP_SNEXT, 7'd0, '0, 8'h00), BUS_NONE, 1, 0, z));
        rows.push_back(row(make_cmd(owm_pkg::OP_SBEGIN, 7'd0, '0, 8'hF0), BUS_PRES_ONLY,
                           1, 0, z));
        rows.push_back(row(make_cmd(owm_pkg::OP_SNEXT, 7'd0, '0, 8'h00), BUS_PRES_ONLY,
                           1, 0, z));
        rows.push_back(row(make_cmd(owm_pkg::OP_SKIP_ROM, 7'd0, '0, 8'h00), BUS_NONE, 1, 0, z));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first idle word checks the state out of reset
        bus_mode = rows[0].mode;
        send_tick(rows[0].w, ign);
        void'(pending_bus_words.pop_back());
        pending_bus_words.push_back(rows[0].want);
        run_to_idle();

        write_timing(1, 1, 1, 1, 1, 1, 1);
        for (int i = 1; i < rows.size(); i++) begin
            bus_mode = rows[i].mode;
            w = rows[i].w;
            w.bus_sample = device_bus_level();
            send_tick(w, ign);
            if (rows[i].typed) begin
                void'(pending_bus_words.pop_back());
                pending_bus_words.push_back(rows[i].want);
            end
            if (rows[i].drain) run_to_idle();
        end

        write_timing(3, 2, 3, 2, 2, 1, 1);
        hold_req <= hold_req + 1;
        random_phase();
        quiet = 1'b1;
        write_timing(1, 1, 1, 1, 1, 1, 1);
        random_phase();
        quiet = 1'b0;
        write_timing(0, 0, 0, 0, 0, 0, 0);
        random_phase();
        // low times past the slot end, sample point past the slot end
        write_timing(2, 2, 2, 2, 3, 3, 5);
        random_phase();

        // widest register values on the low and sample times
        write_timing(1, 1, 1, 2, 1023, 1023, 1023);
        bus_mode = BUS_ONE;
        send_tick(make_cmd(owm_pkg::OP_RESET, 7'd0, '0, 8'h00), ign);
        run_to_idle();
        send_tick(make_cmd(owm_pkg::OP_WRITE, 7'd1, 64'd0, 8'h00), ign);
        run_to_idle();
        send_tick(make_cmd(owm_pkg::OP_READ, 7'd1, '0, 8'h00), ign);
        run_to_idle();

        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
